[design/esd_pkg.sv]
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types, character codes and lookup functions for the escape decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam int BYTE_W = 8;
    localparam int NIBBLE_W = 4;

    // character codes
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_X      = 8'h78;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UC_F   = 8'h46;
    localparam logic [BYTE_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LC_F   = 8'h66;
    localparam logic [BYTE_W-1:0] CH_UC_E   = 8'h45;
    localparam logic [BYTE_W-1:0] CH_LC_B   = 8'h62;
    localparam logic [BYTE_W-1:0] CH_LC_FF  = 8'h66;
    localparam logic [BYTE_W-1:0] CH_LC_T   = 8'h74;
    localparam logic [BYTE_W-1:0] CH_LC_R   = 8'h72;
    localparam logic [BYTE_W-1:0] CH_LC_N   = 8'h6E;

    // decoded control characters
    localparam logic [BYTE_W-1:0] CODE_ESC = 8'd27;
    localparam logic [BYTE_W-1:0] CODE_BS  = 8'd8;
    localparam logic [BYTE_W-1:0] CODE_FF  = 8'd12;
    localparam logic [BYTE_W-1:0] CODE_TAB = 8'd9;
    localparam logic [BYTE_W-1:0] CODE_CR  = 8'd13;
    localparam logic [BYTE_W-1:0] CODE_LF  = 8'd10;

    // escape parser state
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_BSLASH = 4'b0010,
        PH_HEX0   = 4'b0100,
        PH_HEX1   = 4'b1000
    } phase_t;

    // one output beat
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } beat_t;

    typedef struct packed {
        logic                ok;
        logic [NIBBLE_W-1:0] val;
    } hex_t;

    typedef struct packed {
        logic              ok;
        logic [BYTE_W-1:0] val;
    } esc_t;

    // hex digit lookup, either case
    function automatic hex_t hex_lookup(input logic [BYTE_W-1:0] c);
        hex_t r;
        r.ok  = 1'b0;
        r.val = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            r.ok  = 1'b1;
            r.val = NIBBLE_W'(c - CH_ZERO);
        end
        else if (c >= CH_UC_A && c <= CH_UC_F)
        begin
            r.ok  = 1'b1;
            r.val = NIBBLE_W'(c - CH_UC_A + 8'd10);
        end
        else if (c >= CH_LC_A && c <= CH_LC_F)
        begin
            r.ok  = 1'b1;
            r.val = NIBBLE_W'(c - CH_LC_A + 8'd10);
        end
        return r;
    endfunction

    // single-letter escapes
    function automatic esc_t esc_lookup(input logic [BYTE_W-1:0] c);
        esc_t r;
        r.ok  = 1'b1;
        r.val = '0;
        unique case (c)
            CH_UC_E:  r.val = CODE_ESC;
            CH_LC_B:  r.val = CODE_BS;
            CH_LC_FF: r.val = CODE_FF;
            CH_LC_T:  r.val = CODE_TAB;
            CH_LC_R:  r.val = CODE_CR;
            CH_LC_N:  r.val = CODE_LF;
            default:  r.ok  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[design/esd_if.sv]
// ----------------------------------------------------------------------------
// esd_in_if / esd_out_if
// Valid/ready channels for raw bytes in and decoded bytes out.
// ----------------------------------------------------------------------------
interface esd_in_if;
    import esd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface esd_out_if;
    import esd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

[design/escape_sequence_decoder_core.sv]
// ----------------------------------------------------------------------------
// escape_sequence_decoder_core
// Backslash escape decoder with hex byte escapes, one raw byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_stream  : raw bytes, in_last flags the final byte of a string.
//   out_stream : decoded bytes, out_last flags the final decoded byte.
//   Each accepted raw byte is decoded in the cycle it is taken and yields
//   zero, one or two beats, written into a four-entry output queue.
//   When the queue is empty, the first beat of an accepted raw byte is
//   offered in the cycle after it is taken; a second beat from the same
//   byte follows it, and beats already queued ahead are delivered first.
//   Throughput: one raw byte per cycle; in_stream.ready is high while the
//   queue has room for two beats, so the queue depth and the drain rate of
//   one beat per cycle set the pace. Decoding never yields more beats than
//   it consumes over a string, so with the receiver always ready the input
//   is never throttled.
//   A final byte always yields at least one beat and clears any pending
//   escape, so strings are independent.
//   Reset empties the queue and returns the parser to idle.
//   When the receiver stalls, the head beat holds and the queue fills;
//   input ready drops once fewer than two entries are free.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_core (
    input  logic      clk,
    input  logic      rst_n,
    esd_in_if.sink    in_stream,
    esd_out_if.source out_stream
);
    import esd_pkg::*;

    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = PTR_W + 1;

    phase_t              phase_reg, phase_next, phase_mid;
    logic [NIBBLE_W-1:0] held_reg, held_next, held_mid;

    beat_t               queue_mem [QDEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    logic                in_fire, out_fire;
    hex_t                hx;
    esc_t                es;
    logic                a_v, b_v, f_v;
    logic [BYTE_W-1:0]   a_b, b_b, f_b;
    logic                fresh;
    beat_t               slot0, slot1;
    logic [1:0]          push_n;

    assign in_fire  = in_stream.valid && in_stream.ready;
    assign out_fire = out_stream.valid && out_stream.ready;
    assign hx       = hex_lookup(in_stream.in_byte);
    assign es       = esc_lookup(in_stream.in_byte);

    // escape parse of the incoming byte
    always_comb
    begin
        a_v       = 1'b0;
        a_b       = '0;
        fresh     = 1'b0;
        phase_mid = PH_IDLE;
        held_mid  = held_reg;
        unique case (phase_reg)
            PH_BSLASH:
            begin
                if (es.ok)
                begin
                    a_v = 1'b1;
                    a_b = es.val;
                end
                else if (in_stream.in_byte == CH_X)
                begin
                    phase_mid = PH_HEX0;
                end
                else
                begin
                    a_v   = 1'b1;
                    a_b   = CH_BSLASH;
                    fresh = 1'b1;
                end
            end
            PH_HEX0:
            begin
                if (hx.ok)
                begin
                    held_mid  = hx.val;
                    phase_mid = PH_HEX1;
                end
                else
                begin
                    a_v   = 1'b1;
                    fresh = 1'b1;
                end
            end
            PH_HEX1:
            begin
                a_v = 1'b1;
                if (hx.ok)
                begin
                    a_b = {held_reg, hx.val};
                end
                else
                begin
                    a_b   = {{(BYTE_W-NIBBLE_W){1'b0}}, held_reg};
                    fresh = 1'b1;
                end
            end
            default:
            begin
                fresh = 1'b1;
            end
        endcase

        // byte handled as a fresh one
        b_v = 1'b0;
        b_b = in_stream.in_byte;
        if (fresh)
        begin
            if (in_stream.in_byte == CH_BSLASH)
                phase_mid = PH_BSLASH;
            else
                b_v = 1'b1;
        end

        // flush of a pending escape on the last byte
        f_v = in_stream.in_last && (phase_mid != PH_IDLE);
        f_b = '0;
        unique case (phase_mid)
            PH_BSLASH: f_b = CH_BSLASH;
            PH_HEX1:   f_b = {{(BYTE_W-NIBBLE_W){1'b0}}, held_mid};
            default:   f_b = '0;
        endcase

        if (in_stream.in_last)
        begin
            phase_next = PH_IDLE;
            held_next  = '0;
        end
        else
        begin
            phase_next = phase_mid;
            held_next  = held_mid;
        end
    end

    // pack up to two beats
    always_comb
    begin
        slot0.data = a_v ? a_b : (b_v ? b_b : f_b);
        slot1.data = (a_v && b_v) ? b_b : f_b;
        push_n     = 2'(a_v) + 2'(b_v) + 2'(f_v);
        slot0.last = in_stream.in_last && (push_n == 2'd1);
        slot1.last = in_stream.in_last;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // output queue storage
    always_ff @(posedge clk)
    begin
        if (in_fire && push_n != 2'd0)
            queue_mem[wr_ptr_reg] <= slot0;
        if (in_fire && push_n == 2'd2)
            queue_mem[wr_ptr_reg + PTR_W'(1)] <= slot1;
    end

    // output queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_fire)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            if (out_fire)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_reg + (in_fire ? CNT_W'(push_n) : '0)
                         - CNT_W'(out_fire);
        end
    end

    assign in_stream.ready     = count_reg <= CNT_W'(QDEPTH - 2);
    assign out_stream.valid    = count_reg != '0;
    assign out_stream.out_byte = queue_mem[rd_ptr_reg].data;
    assign out_stream.out_last = queue_mem[rd_ptr_reg].last;

endmodule

[design/esd_checker.sv]
// ----------------------------------------------------------------------------
// esd_checker
// Port-level checks for the escape decoder, bound to escape_sequence_decoder_core.
// ----------------------------------------------------------------------------
module esd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last
);

    // a final byte always leaves a beat to deliver
    a_last_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> out_valid)
        else $error("final byte produced no output beat");

    // input back-pressure only when results are queued
    a_ready_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    // stalled beat stays valid
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    // stalled beat keeps its payload
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
        else $error("output payload changed while stalled");

endmodule

bind escape_sequence_decoder_core esd_checker u_esd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .in_last   (in_stream.in_last),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .out_byte  (out_stream.out_byte),
    .out_last  (out_stream.out_last)
);
